[rtl/hrf_pkg.sv]
package hrf_pkg;

  localparam int MAX_LEN = 4096;
  localparam int POS_W   = $clog2(MAX_LEN + 1);
  localparam int OFS_W   = 13;
  localparam int CODE_W  = 3;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [OFS_W-1:0]  ofs_t;
  typedef logic [CODE_W-1:0] code_t;

  localparam pos_t MAX_POS = POS_W'(MAX_LEN);

  localparam code_t RC_NO_BLANK = 3'd0;
  localparam code_t RC_NO_MSP   = 3'd1;
  localparam code_t RC_NO_USP   = 3'd2;
  localparam code_t RC_SUCCESS  = 3'd3;
  localparam code_t RC_OVERFLOW = 3'd4;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_QM  = 8'h3f;

  typedef struct packed {
    logic found;
    pos_t pos;
  } loc_t;

  typedef struct packed {
    logic ovf;
    loc_t dcrlf;
    loc_t dlf;
    loc_t fcrlf;
    loc_t flf;
    loc_t sp1;
    loc_t sp2;
    loc_t qm;
  } scan_t;

  typedef struct packed {
    logic ovf;
    logic blank;
    pos_t line_end;
    pos_t hdr;
    pos_t body;
    loc_t sp1;
    loc_t sp2;
    loc_t qm;
  } frame_t;

  function automatic ofs_t to_ofs(pos_t p);
    logic [31:0] w;
    w = 32'(p);
    return w[OFS_W-1:0];
  endfunction

endpackage

[rtl/hrf_front.sv]
module hrf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic [7:0]     data_i,
  input  logic           last_i,
  input  logic           full_i,
  output logic           push_o,
  output hrf_pkg::scan_t rec_o
);

  hrf_pkg::pos_t  pos_q, pos_d;
  logic [23:0]    recent_q, recent_d;
  logic           ended_q, ended_d;
  hrf_pkg::scan_t scan_q, scan_d;
  logic           beat;
  logic [7:0]     b1, b2, b3;

  assign ready_o = !full_i;
  assign beat    = valid_i && ready_o;
  assign push_o  = beat && last_i;
  assign rec_o   = scan_d;

  assign b1 = recent_q[7:0];
  assign b2 = recent_q[15:8];
  assign b3 = recent_q[23:16];

  always_comb begin
    pos_d    = pos_q;
    recent_d = recent_q;
    ended_d  = ended_q;
    scan_d   = scan_q;
    if (!ended_q && !scan_q.ovf) begin
      if (data_i == hrf_pkg::CH_NUL) begin
        ended_d = 1'b1;
      end else if (pos_q == hrf_pkg::MAX_POS) begin
        scan_d.ovf = 1'b1;
      end else begin
        if (data_i == hrf_pkg::CH_LF) begin
          if (!scan_q.dcrlf.found && b3 == hrf_pkg::CH_CR && b2 == hrf_pkg::CH_LF &&
              b1 == hrf_pkg::CH_CR) begin
            scan_d.dcrlf = '{found: 1'b1, pos: pos_q - hrf_pkg::POS_W'(3)};
          end
          if (!scan_q.dlf.found && b1 == hrf_pkg::CH_LF) begin
            scan_d.dlf = '{found: 1'b1, pos: pos_q - hrf_pkg::POS_W'(1)};
          end
          if (!scan_q.fcrlf.found && b1 == hrf_pkg::CH_CR) begin
            scan_d.fcrlf = '{found: 1'b1, pos: pos_q - hrf_pkg::POS_W'(1)};
          end
          if (!scan_q.flf.found) begin
            scan_d.flf = '{found: 1'b1, pos: pos_q};
          end
        end else if (data_i == hrf_pkg::CH_SP) begin
          if (!scan_q.sp1.found) begin
            scan_d.sp1 = '{found: 1'b1, pos: pos_q};
          end else if (!scan_q.sp2.found) begin
            scan_d.sp2 = '{found: 1'b1, pos: pos_q};
          end
        end else if (data_i == hrf_pkg::CH_QM) begin
          if (scan_q.sp1.found && !scan_q.qm.found) begin
            scan_d.qm = '{found: 1'b1, pos: pos_q};
          end
        end
        recent_d = {recent_q[15:0], data_i};
        pos_d    = pos_q + hrf_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      recent_q <= '0;
      ended_q  <= 1'b0;
      scan_q   <= '0;
    end else if (beat) begin
      if (last_i) begin
        pos_q    <= '0;
        recent_q <= '0;
        ended_q  <= 1'b0;
        scan_q   <= '0;
      end else begin
        pos_q    <= pos_d;
        recent_q <= recent_d;
        ended_q  <= ended_d;
        scan_q   <= scan_d;
      end
    end
  end

endmodule

[rtl/hrf_queue.sv]
module hrf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hrf_pkg::scan_t data_i,
  input  logic           pop_i,
  output hrf_pkg::scan_t data_o,
  output logic           full_o,
  output logic           empty_o
);

  hrf_pkg::scan_t                    mem_q [hrf_pkg::QDEPTH];
  logic [hrf_pkg::QPTR_W-1:0]        wr_ptr_q, rd_ptr_q;
  logic [hrf_pkg::QCNT_W-1:0]        cnt_q;
  logic                              do_push, do_pop;

  assign full_o  = cnt_q == hrf_pkg::QCNT_W'(hrf_pkg::QDEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [hrf_pkg::QPTR_W-1:0] bump(logic [hrf_pkg::QPTR_W-1:0] p);
    return (p == hrf_pkg::QPTR_W'(hrf_pkg::QDEPTH - 1)) ? '0 : p + hrf_pkg::QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= bump(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= bump(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + hrf_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - hrf_pkg::QCNT_W'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= hrf_pkg::QCNT_W'(hrf_pkg::QDEPTH))
    else $error("queue fill beyond depth");

endmodule

[rtl/hrf_back.sv]
module hrf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  hrf_pkg::scan_t rec_i,
  output logic           pop_o,
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  output logic [95:0]    m_axis_tdata_o
);

  hrf_pkg::frame_t fr_d, fr_q;
  logic            fr_v_q;
  logic            out_v_q;
  logic            out_ready, fr_ready;
  hrf_pkg::pos_t   cut;

  hrf_pkg::code_t  code_d, code_q;
  hrf_pkg::ofs_t   me_d, us_d, ue_d, qs_d, vs_d, hs_d, bs_d;
  hrf_pkg::ofs_t   me_q, us_q, ue_q, qs_q, vs_q, hs_q, bs_q;
  logic            qp_d, qp_q;

  assign out_ready = !out_v_q || m_axis_tready_i;
  assign fr_ready  = !fr_v_q || out_ready;
  assign pop_o     = valid_i && fr_ready;

  always_comb begin
    fr_d.ovf   = rec_i.ovf;
    fr_d.blank = rec_i.dcrlf.found || rec_i.dlf.found;
    fr_d.sp1   = rec_i.sp1;
    fr_d.sp2   = rec_i.sp2;
    fr_d.qm    = rec_i.qm;
    if (rec_i.dcrlf.found) begin
      cut       = rec_i.dcrlf.pos + hrf_pkg::POS_W'(2);
      fr_d.body = rec_i.dcrlf.pos + hrf_pkg::POS_W'(4);
    end else begin
      cut       = rec_i.dlf.pos + hrf_pkg::POS_W'(1);
      fr_d.body = rec_i.dlf.pos + hrf_pkg::POS_W'(2);
    end
    if (rec_i.fcrlf.found && (rec_i.fcrlf.pos + hrf_pkg::POS_W'(1)) < cut) begin
      fr_d.line_end = rec_i.fcrlf.pos;
      fr_d.hdr      = rec_i.fcrlf.pos + hrf_pkg::POS_W'(2);
    end else if (rec_i.flf.found && rec_i.flf.pos < cut) begin
      fr_d.line_end = rec_i.flf.pos;
      fr_d.hdr      = rec_i.flf.pos + hrf_pkg::POS_W'(1);
    end else begin
      fr_d.line_end = cut;
      fr_d.hdr      = cut;
    end
  end

  always_comb begin
    code_d = hrf_pkg::RC_NO_BLANK;
    me_d   = '0;
    us_d   = '0;
    ue_d   = '0;
    qp_d   = 1'b0;
    qs_d   = '0;
    vs_d   = '0;
    hs_d   = '0;
    bs_d   = '0;
    if (fr_q.ovf) begin
      code_d = hrf_pkg::RC_OVERFLOW;
    end else if (fr_q.blank) begin
      hs_d = hrf_pkg::to_ofs(fr_q.hdr);
      bs_d = hrf_pkg::to_ofs(fr_q.body);
      if (!fr_q.sp1.found || fr_q.sp1.pos >= fr_q.line_end) begin
        code_d = hrf_pkg::RC_NO_MSP;
      end else begin
        me_d = hrf_pkg::to_ofs(fr_q.sp1.pos);
        us_d = hrf_pkg::to_ofs(fr_q.sp1.pos + hrf_pkg::POS_W'(1));
        if (!fr_q.sp2.found || fr_q.sp2.pos >= fr_q.line_end) begin
          code_d = hrf_pkg::RC_NO_USP;
        end else begin
          code_d = hrf_pkg::RC_SUCCESS;
          vs_d   = hrf_pkg::to_ofs(fr_q.sp2.pos + hrf_pkg::POS_W'(1));
          if (fr_q.qm.found && fr_q.qm.pos < fr_q.sp2.pos) begin
            qp_d = 1'b1;
            ue_d = hrf_pkg::to_ofs(fr_q.qm.pos);
            qs_d = hrf_pkg::to_ofs(fr_q.qm.pos + hrf_pkg::POS_W'(1));
          end else begin
            ue_d = hrf_pkg::to_ofs(fr_q.sp2.pos);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      fr_q <= fr_d;
    end
    if (fr_v_q && out_ready) begin
      code_q <= code_d;
      me_q   <= me_d;
      us_q   <= us_d;
      ue_q   <= ue_d;
      qp_q   <= qp_d;
      qs_q   <= qs_d;
      vs_q   <= vs_d;
      hs_q   <= hs_d;
      bs_q   <= bs_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (fr_ready) begin
        fr_v_q <= valid_i;
      end
      if (out_ready) begin
        out_v_q <= fr_v_q;
      end
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {1'b0, bs_q, hs_q, vs_q, qs_q, qp_q, ue_q, us_q, me_q, code_q};

  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && code_q == hrf_pkg::RC_OVERFLOW |->
      me_q == '0 && hs_q == '0 && bs_q == '0 && !qp_q)
    else $error("overflow result with offsets");

  a_query_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && qp_q |-> code_q == hrf_pkg::RC_SUCCESS)
    else $error("query mark without complete request line");

  a_path_ver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && code_q == hrf_pkg::RC_SUCCESS && !qp_q |->
      hrf_pkg::ofs_t'(ue_q + hrf_pkg::OFS_W'(1)) == vs_q)
    else $error("path end and version start disagree");

  a_uri_after_method: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (code_q == hrf_pkg::RC_SUCCESS || code_q == hrf_pkg::RC_NO_USP) |->
      hrf_pkg::ofs_t'(me_q + hrf_pkg::OFS_W'(1)) == us_q)
    else $error("uri start not after method space");

endmodule

[rtl/http_request_framer.sv]
// channel  dir  tdata fields (low bit up)                      tuser  tlast
// s_axis   in   data_byte[7:0]                                 -      last_byte
// m_axis   out  result_code[2:0] method_end[15:3]               -      -
//               uri_start[28:16] uri_end[41:29]
//               query_present[42] query_start[55:43]
//               version_start[68:56] header_start[81:69]
//               body_start[94:82] zero[95]
//
// One byte a cycle through the scanner registers while the result queue is not
// full; after the last byte is taken, the result passes through the queue, the
// framing stage and the output register before its beat is valid.
// Reset clears the scanner state, the queue and both valid stages.
// s_axis_tready_o falls only while the two-entry result queue is full.
module http_request_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // data_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [95:0] m_axis_tdata_o   // result_code .. body_start, see table
);

  hrf_pkg::scan_t push_rec, head_rec;
  logic           push, pop, full, empty;

  hrf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  (s_axis_tdata_i),
    .last_i  (s_axis_tlast_i),
    .full_i  (full),
    .push_o  (push),
    .rec_o   (push_rec)
  );

  hrf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_rec),
    .pop_i   (pop),
    .data_o  (head_rec),
    .full_o  (full),
    .empty_o (empty)
  );

  hrf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (!empty),
    .rec_i           (head_rec),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int    QUIET_LIMIT = 5000;
  localparam int    RAND_BYTES  = 450;
  localparam string CRLF        = "\015\012";
  localparam string LF          = "\012";

  typedef struct packed {
    logic           pad;
    hrf_pkg::ofs_t  body_start;
    hrf_pkg::ofs_t  header_start;
    hrf_pkg::ofs_t  version_start;
    hrf_pkg::ofs_t  query_start;
    logic           query_present;
    hrf_pkg::ofs_t  uri_end;
    hrf_pkg::ofs_t  uri_start;
    hrf_pkg::ofs_t  method_end;
    hrf_pkg::code_t result_code;
  } frame_info_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    int         ph;
  } text_beat_t;

  typedef struct {
    logic        seen;
    logic [13:0] at;
  } mark_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [95:0] m_axis_tdata_o;

  text_beat_t  text_q[$];
  logic [7:0]  req_q[$];
  frame_info_t frames_due[$];

  int src_idle[3]  = '{22, 58, 0};
  int sink_idle[3] = '{58, 22, 0};
  int cur_ph = 0;

  logic beat_taken = 1'b0;
  int   quiet_cycles = 0;
  int   n_errors = 0;
  int   n_reqs = 0;
  int   n_bytes = 0;
  int   n_frames = 0;

  logic [13:0] scan_pos;
  logic [23:0] scan_tail;
  logic        text_done;
  mark_t       dcrlf, dlf, fcrlf, flf, sp1, sp2, qm;

  http_request_framer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #2 clk_i = ~clk_i;

  task automatic clear_scan();
    scan_pos  = '0;
    scan_tail = '0;
    text_done = 1'b0;
    dcrlf = '{1'b0, '0};
    dlf   = '{1'b0, '0};
    fcrlf = '{1'b0, '0};
    flf   = '{1'b0, '0};
    sp1   = '{1'b0, '0};
    sp2   = '{1'b0, '0};
    qm    = '{1'b0, '0};
  endtask

  task automatic frame_byte(input logic [7:0] b, input logic last);
    frame_info_t r;
    logic [7:0]  b1, b2, b3;
    int          cut, line_end, hdr, body;
    r = '0;
    if (!text_done && scan_pos <= 14'(hrf_pkg::MAX_LEN)) begin
      if (b == hrf_pkg::CH_NUL) begin
        text_done = 1'b1;
      end else if (scan_pos == 14'(hrf_pkg::MAX_LEN)) begin
        scan_pos = 14'(hrf_pkg::MAX_LEN + 1);
      end else begin
        b1 = scan_tail[7:0];
        b2 = scan_tail[15:8];
        b3 = scan_tail[23:16];
        if (b == hrf_pkg::CH_LF) begin
          if (!dcrlf.seen && b3 == hrf_pkg::CH_CR && b2 == hrf_pkg::CH_LF &&
              b1 == hrf_pkg::CH_CR)
            dcrlf = '{1'b1, scan_pos - 14'd3};
          if (!dlf.seen && b1 == hrf_pkg::CH_LF) dlf = '{1'b1, scan_pos - 14'd1};
          if (!fcrlf.seen && b1 == hrf_pkg::CH_CR) fcrlf = '{1'b1, scan_pos - 14'd1};
          if (!flf.seen) flf = '{1'b1, scan_pos};
        end else if (b == hrf_pkg::CH_SP) begin
          if (!sp1.seen) sp1 = '{1'b1, scan_pos};
          else if (!sp2.seen) sp2 = '{1'b1, scan_pos};
        end else if (b == hrf_pkg::CH_QM) begin
          if (sp1.seen && !qm.seen) qm = '{1'b1, scan_pos};
        end
        scan_tail = {scan_tail[15:0], b};
        scan_pos  = scan_pos + 14'd1;
      end
    end
    if (last) begin
      if (scan_pos > 14'(hrf_pkg::MAX_LEN)) begin
        r.result_code = hrf_pkg::RC_OVERFLOW;
      end else if (dcrlf.seen || dlf.seen) begin
        if (dcrlf.seen) begin
          cut  = int'(dcrlf.at) + 2;
          body = int'(dcrlf.at) + 4;
        end else begin
          cut  = int'(dlf.at) + 1;
          body = int'(dlf.at) + 2;
        end
        if (fcrlf.seen && int'(fcrlf.at) + 1 < cut) begin
          line_end = int'(fcrlf.at);
          hdr      = int'(fcrlf.at) + 2;
        end else if (flf.seen && int'(flf.at) < cut) begin
          line_end = int'(flf.at);
          hdr      = int'(flf.at) + 1;
        end else begin
          line_end = cut;
          hdr      = cut;
        end
        r.body_start   = hrf_pkg::ofs_t'(body);
        r.header_start = hrf_pkg::ofs_t'(hdr);
        if (!sp1.seen || int'(sp1.at) >= line_end) begin
          r.result_code = hrf_pkg::RC_NO_MSP;
        end else begin
          r.method_end = hrf_pkg::ofs_t'(sp1.at);
          r.uri_start  = hrf_pkg::ofs_t'(int'(sp1.at) + 1);
          if (!sp2.seen || int'(sp2.at) >= line_end) begin
            r.result_code = hrf_pkg::RC_NO_USP;
          end else begin
            r.result_code   = hrf_pkg::RC_SUCCESS;
            r.version_start = hrf_pkg::ofs_t'(int'(sp2.at) + 1);
            if (qm.seen && qm.at < sp2.at) begin
              r.query_present = 1'b1;
              r.uri_end       = hrf_pkg::ofs_t'(qm.at);
              r.query_start   = hrf_pkg::ofs_t'(int'(qm.at) + 1);
            end else begin
              r.uri_end = hrf_pkg::ofs_t'(sp2.at);
            end
          end
        end
      end else begin
        r.result_code = hrf_pkg::RC_NO_BLANK;
      end
      frames_due.push_back(r);
      clear_scan();
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) req_q.push_back(s[i]);
  endtask

  task automatic put_eol(input logic lf_only);
    if (lf_only) put_str(LF);
    else put_str(CRLF);
  endtask

  function automatic logic [7:0] noisy_byte();
    case ($urandom_range(0, 7))
      0: return hrf_pkg::CH_CR;
      1: return hrf_pkg::CH_LF;
      2: return hrf_pkg::CH_SP;
      3: return hrf_pkg::CH_QM;
      4: return hrf_pkg::CH_NUL;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_req(input int ph);
    for (int i = 0; i < req_q.size(); i++)
      text_q.push_back('{req_q[i], i == req_q.size() - 1, ph});
    req_q.delete();
    n_reqs++;
  endtask

  task automatic put_random_request();
    logic lf_only;
    int   n;
    lf_only = ($urandom_range(0, 3) == 0);
    n = $urandom_range(1, 6);
    repeat (n) req_q.push_back(8'h41 + 8'($urandom_range(0, 25)));
    put_str(" ");
    if ($urandom_range(0, 9) != 0) put_str("/");
    n = $urandom_range(0, 8);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) req_q.push_back(hrf_pkg::CH_QM);
      else req_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
    end
    if ($urandom_range(0, 9) != 0) put_str(" ");
    put_str("HTTP/1.");
    req_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
    put_eol(lf_only);
    n = $urandom_range(0, 2);
    repeat (n) begin
      put_str("H: ");
      req_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
      put_eol(lf_only);
    end
    put_eol(($urandom_range(0, 7) == 0) ? !lf_only : lf_only);
    if ($urandom_range(0, 5) == 0) req_q.push_back(hrf_pkg::CH_NUL);
    n = $urandom_range(0, 4);
    repeat (n) req_q.push_back(8'($urandom_range(0, 255)));
    case ($urandom_range(0, 9))
      0: req_q = req_q[0:$urandom_range(0, req_q.size() - 1)];
      1: req_q.insert($urandom_range(0, req_q.size() - 1), noisy_byte());
      default: ;
    endcase
  endtask

  always @(negedge clk_i) begin
    text_beat_t nb;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= sink_idle[cur_ph]);
      if (!s_axis_tvalid_i || beat_taken) begin
        if (text_q.size() != 0 && $urandom_range(0, 99) >= src_idle[text_q[0].ph]) begin
          nb = text_q.pop_front();
          cur_ph = nb.ph;
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= nb.data;
          s_axis_tlast_i  <= nb.last;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    frame_info_t want, got;
    logic        s_fire, m_fire;
    s_fire = s_axis_tvalid_i && s_axis_tready_o;
    m_fire = m_axis_tvalid_o && m_axis_tready_i;
    beat_taken <= s_fire;
    if (rst_ni) begin
      if (s_fire) begin
        frame_byte(s_axis_tdata_i, s_axis_tlast_i);
        n_bytes++;
      end
      if (m_fire) begin
        got = frame_info_t'(m_axis_tdata_o);
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, m_axis_tdata_o);
          n_errors++;
        end else begin
          want = frames_due.pop_front();
          check_field("result_code", int'(want.result_code), int'(got.result_code));
          check_field("method_end", int'(want.method_end), int'(got.method_end));
          check_field("uri_start", int'(want.uri_start), int'(got.uri_start));
          check_field("uri_end", int'(want.uri_end), int'(got.uri_end));
          check_field("query_present", int'(want.query_present), int'(got.query_present));
          check_field("query_start", int'(want.query_start), int'(got.query_start));
          check_field("version_start", int'(want.version_start), int'(got.version_start));
          check_field("header_start", int'(want.header_start), int'(got.header_start));
          check_field("body_start", int'(want.body_start), int'(got.body_start));
          check_field("pad", int'(want.pad), int'(got.pad));
          n_frames++;
        end
      end
      if (s_fire || m_fire) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: watchdog, no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int start;
    clear_scan();

    put_str({"GET / HTTP/1.1", CRLF, CRLF});                        send_req(0);
    put_str({"GET /a?b=1 HTTP/1.0", CRLF, "Host: x", CRLF, CRLF, "body"});
    send_req(0);
    put_str({"GET / HTTP/1.1", LF, LF});                            send_req(0);
    put_str({"GETX", CRLF, CRLF});                                  send_req(0);
    put_str({"GET /x", CRLF, CRLF});                                send_req(0);
    put_str("abc");                                                 send_req(0);
    put_str("GET / HT");
    req_q.push_back(hrf_pkg::CH_NUL);
    put_str({"TP", CRLF, CRLF});                                    send_req(0);
    req_q.push_back(hrf_pkg::CH_NUL);                               send_req(0);
    req_q.push_back(8'hFF);                                         send_req(0);
    put_str({"A B C", LF, LF, "X", CRLF, CRLF});                    send_req(0);
    put_str({"GET /p HTTP?", CRLF, CRLF});                          send_req(0);
    put_str({"G?T /p HTTP", CRLF, CRLF});                           send_req(0);
    put_str({"GET / H", LF, "X", CRLF, CRLF});                      send_req(0);
    put_str({"GET /a HTTP/1.1", CRLF, "K: v", LF, LF});             send_req(0);
    put_str({" ", CRLF, CRLF});                                     send_req(0);

    for (int ph = 0; ph < 3; ph++) begin
      start = text_q.size();
      while (text_q.size() - start < RAND_BYTES) begin
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 20)) req_q.push_back(noisy_byte());
        end else begin
          put_random_request();
        end
        send_req(ph);
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (text_q.size() != 0 || s_axis_tvalid_i || frames_due.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d requests in %0d byte beats, %0d result beats checked,",
             n_reqs, n_bytes, n_frames);
    $display("including line-break variants, text end and broken input.");
    if (n_errors == 0 && frames_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
